@@ rtl/xml_text_escaper_defines.svh @@
// ----------------------------------------------------------------------------
// xml_text_escaper_defines.svh
// Assertion macros shared by the escaper modules.
// ----------------------------------------------------------------------------
`ifndef XML_TEXT_ESCAPER_DEFINES_SVH
`define XML_TEXT_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
`define XTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define XTE_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define XTE_ASSERT(lbl, prop, msg)
`define XTE_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/xte_pkg.sv @@
// ----------------------------------------------------------------------------
// xte_pkg
// Types, character constants and entity tables of the XML text escaper.
// ----------------------------------------------------------------------------
package xte_pkg;

	localparam int UNIT_W = 16;
	localparam int IDX_W  = 3;

	localparam logic [UNIT_W-1:0] CTRL_LIMIT = 16'h0020;
	localparam logic [UNIT_W-1:0] CH_TAB     = 16'h0009;
	localparam logic [UNIT_W-1:0] CH_LF      = 16'h000A;
	localparam logic [UNIT_W-1:0] CH_CR      = 16'h000D;
	localparam logic [UNIT_W-1:0] CH_QUOT    = 16'h0022;
	localparam logic [UNIT_W-1:0] CH_AMP     = 16'h0026;
	localparam logic [UNIT_W-1:0] CH_APOS    = 16'h0027;
	localparam logic [UNIT_W-1:0] CH_SEMI    = 16'h003B;
	localparam logic [UNIT_W-1:0] CH_LT      = 16'h003C;
	localparam logic [UNIT_W-1:0] CH_GT      = 16'h003E;
	localparam logic [UNIT_W-1:0] CH_A       = 16'h0061;
	localparam logic [UNIT_W-1:0] CH_G       = 16'h0067;
	localparam logic [UNIT_W-1:0] CH_L       = 16'h006C;
	localparam logic [UNIT_W-1:0] CH_M       = 16'h006D;
	localparam logic [UNIT_W-1:0] CH_O       = 16'h006F;
	localparam logic [UNIT_W-1:0] CH_P       = 16'h0070;
	localparam logic [UNIT_W-1:0] CH_Q       = 16'h0071;
	localparam logic [UNIT_W-1:0] CH_S       = 16'h0073;
	localparam logic [UNIT_W-1:0] CH_T       = 16'h0074;
	localparam logic [UNIT_W-1:0] CH_U       = 16'h0075;

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_AMP,
		KIND_LT,
		KIND_GT,
		KIND_QUOT,
		KIND_APOS
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [UNIT_W-1:0] unit;
	} xte_entry_t;

	// Index of the last unit of the run for each kind.
	function automatic logic [IDX_W-1:0] ent_last(input kind_t kind);
		logic [IDX_W-1:0] r;
		unique case (kind)
			KIND_AMP:  r = IDX_W'(4);
			KIND_LT:   r = IDX_W'(3);
			KIND_GT:   r = IDX_W'(3);
			KIND_QUOT: r = IDX_W'(5);
			KIND_APOS: r = IDX_W'(5);
			default:   r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [UNIT_W-1:0] ent_unit(input kind_t kind,
			input logic [IDX_W-1:0] idx, input logic [UNIT_W-1:0] unit);
		logic [UNIT_W-1:0] r;
		r = CH_SEMI;
		unique case (kind)
			KIND_AMP: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_A;
					3'd2:    r = CH_M;
					3'd3:    r = CH_P;
					default: r = CH_SEMI;
				endcase
			end
			KIND_LT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_L;
					3'd2:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_GT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_G;
					3'd2:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_QUOT: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_Q;
					3'd2:    r = CH_U;
					3'd3:    r = CH_O;
					3'd4:    r = CH_T;
					default: r = CH_SEMI;
				endcase
			end
			KIND_APOS: begin
				unique case (idx)
					3'd0:    r = CH_AMP;
					3'd1:    r = CH_A;
					3'd2:    r = CH_P;
					3'd3:    r = CH_O;
					3'd4:    r = CH_S;
					default: r = CH_SEMI;
				endcase
			end
			default: r = unit;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/xte_if.sv @@
// ----------------------------------------------------------------------------
// xte_if
// Valid/ready stream interfaces for text input and escaped output.
// ----------------------------------------------------------------------------
interface xte_in_if import xte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;

	modport source(output valid, output code_unit, input ready);
	modport sink(input valid, input code_unit, output ready);
endinterface

interface xte_out_if import xte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] out_unit;
	logic              run_end;

	modport source(output valid, output out_unit, output run_end, input ready);
	modport sink(input valid, input out_unit, input run_end, output ready);
endinterface

@@ rtl/xte_front.sv @@
// ----------------------------------------------------------------------------
// xte_front
// Accepts code units, drops disallowed control units and classifies the rest.
// ----------------------------------------------------------------------------
module xte_front import xte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	xte_in_if.sink     text_in,
	output logic       push_valid,
	output xte_entry_t push_entry,
	input  logic       push_ready
);

	logic       valid_s1;
	xte_entry_t entry_s1;
	logic       take;
	logic       drop;
	kind_t      kind;

	always_comb begin
		drop = (text_in.code_unit < CTRL_LIMIT) && (text_in.code_unit != CH_TAB)
			&& (text_in.code_unit != CH_LF) && (text_in.code_unit != CH_CR);
		priority if (text_in.code_unit == CH_AMP) begin
			kind = KIND_AMP;
		end else if (text_in.code_unit == CH_LT) begin
			kind = KIND_LT;
		end else if (text_in.code_unit == CH_GT) begin
			kind = KIND_GT;
		end else if (text_in.code_unit == CH_QUOT) begin
			kind = KIND_QUOT;
		end else if (text_in.code_unit == CH_APOS) begin
			kind = KIND_APOS;
		end else begin
			kind = KIND_PASS;
		end
	end

	assign text_in.ready = !valid_s1 || push_ready;
	assign take          = text_in.valid && text_in.ready;
	assign push_valid    = valid_s1;
	assign push_entry    = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= !drop;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.kind <= kind;
			entry_s1.unit <= text_in.code_unit;
		end
	end

endmodule

@@ rtl/xte_queue.sv @@
// ----------------------------------------------------------------------------
// xte_queue
// Short register queue between the classifier and the run generator.
// ----------------------------------------------------------------------------
`include "xml_text_escaper_defines.svh"

module xte_queue import xte_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  xte_entry_t push_entry,
	output logic       push_ready,
	output logic       pop_valid,
	output xte_entry_t pop_entry,
	input  logic       pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xte_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`XTE_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "Queue count exceeds depth.")
	`XTE_ASSERT_NEVER(a_pop_empty, pop && (count_q == '0), "Pop from empty queue.")
	`XTE_ASSERT(a_push_counts, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "Push lost.")

endmodule

@@ rtl/xte_back.sv @@
// ----------------------------------------------------------------------------
// xte_back
// Expands queued entries into runs of code units through an output register.
// ----------------------------------------------------------------------------
`include "xml_text_escaper_defines.svh"

module xte_back import xte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  xte_entry_t pop_entry,
	output logic       pop,
	xte_out_if.source  text_out
);

	logic              busy_q;
	xte_entry_t        cur_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [UNIT_W-1:0] out_unit_q;
	logic              out_end_q;
	logic              emit;
	logic              last;

	assign emit = busy_q && (!out_valid_q || text_out.ready);
	assign last = (idx_q == ent_last(cur_q.kind));
	assign pop  = pop_valid && (!busy_q || (emit && last));

	assign text_out.valid    = out_valid_q;
	assign text_out.out_unit = out_unit_q;
	assign text_out.run_end  = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (text_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
		end
		if (emit) begin
			out_unit_q <= ent_unit(cur_q.kind, idx_q, cur_q.unit);
			out_end_q  <= last;
		end
	end

	`XTE_ASSERT(a_pass_single, (busy_q && cur_q.kind == KIND_PASS) |-> (idx_q == '0), "Pass run too long.")
	`XTE_ASSERT(a_idx_in_run, busy_q |-> (idx_q <= ent_last(cur_q.kind)), "Run index overflow.")
	`XTE_ASSERT(a_emit_loads, emit |=> (text_out.valid && (text_out.run_end == $past(last))), "Emit lost.")

endmodule

@@ rtl/xml_text_escaper.sv @@
// An accepted code unit passes the input stage, the queue and the run generator to the output register.
// Throughput: one code unit per cycle in and one escaped unit per cycle out while the output is ready.
// An entity reference holds the run generator for a run of four to six units; the queue
// and the input stage keep accepting until they fill. A dropped unit never reaches the queue.
// Reset clears the stage valid flags, queue pointers and the output register flag.
// ----------------------------------------------------------------------------
// xml_text_escaper
// XML 1.0 text escaping of a stream of UTF-16 code units.
// ----------------------------------------------------------------------------
module xml_text_escaper import xte_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	xte_in_if.sink    text_in,
	xte_out_if.source text_out
);

	logic       push_valid;
	logic       push_ready;
	xte_entry_t push_entry;
	logic       pop_valid;
	logic       pop;
	xte_entry_t pop_entry;

	xte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	xte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	xte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.text_out  (text_out)
	);

endmodule

@@ tb/xml_text_escaper_tb.sv @@
// ----------------------------------------------------------------------------
// xml_text_escaper_tb
// Self-checking bench for the XML text escaper. A driver plays a queue of
// code units into the input stream and a monitor compares every escaped unit
// with the run predicted for each accepted code unit. Both streams idle at
// random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module xml_text_escaper_tb;
	import xte_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_UNITS  = 205;
	localparam int DRAIN_AT      = 120;
	localparam int HOLD_AFTER    = 60;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [UNIT_W-1:0] unit;
		bit                drain_first;
	} text_item_t;

	typedef struct {
		logic [UNIT_W-1:0] unit;
		logic              run_end;
	} escaped_unit_t;

	logic clk;
	logic arst_n;

	xte_in_if  text_in();
	xte_out_if text_out();

	xml_text_escaper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	text_item_t    text_pending[$];
	escaped_unit_t escaped_due[$];
	int            units_queued;
	int            units_accepted;
	int            results_seen;
	int            mismatches;
	logic          in_taken;
	logic          out_taken;
	int            send_gap;
	bit            send_burst;
	int            recv_wait;
	int            recv_hold;
	bit            recv_held;
	bit            recv_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n            = 1'b0;
		text_in.valid     = 1'b0;
		text_in.code_unit = '0;
		text_out.ready    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic kind_t markup_kind(input logic [UNIT_W-1:0] u);
		case (u)
			CH_AMP:  return KIND_AMP;
			CH_LT:   return KIND_LT;
			CH_GT:   return KIND_GT;
			CH_QUOT: return KIND_QUOT;
			CH_APOS: return KIND_APOS;
			default: return KIND_PASS;
		endcase
	endfunction

	// Appends the escaped run of one code unit; dropped control units add nothing.
	function automatic void predict_escape(input logic [UNIT_W-1:0] u);
		string         entity;
		escaped_unit_t e;
		if (u < CTRL_LIMIT && u != CH_TAB && u != CH_LF && u != CH_CR)
			return;
		case (markup_kind(u))
			KIND_AMP:  entity = "&amp;";
			KIND_LT:   entity = "&lt;";
			KIND_GT:   entity = "&gt;";
			KIND_QUOT: entity = "&quot;";
			KIND_APOS: entity = "&apos;";
			default:   entity = "";
		endcase
		if (entity.len() == 0) begin
			e.unit    = u;
			e.run_end = 1'b1;
			escaped_due.push_back(e);
		end else begin
			for (int i = 0; i < entity.len(); i++) begin
				e.unit    = UNIT_W'(entity[i]);
				e.run_end = (i == entity.len() - 1);
				escaped_due.push_back(e);
			end
		end
	endfunction

	function automatic void queue_unit(input logic [UNIT_W-1:0] u, input bit drain_first);
		text_item_t item;
		item.unit        = u;
		item.drain_first = drain_first;
		text_pending.push_back(item);
		units_queued++;
	endfunction

	function automatic logic [UNIT_W-1:0] random_unit();
		logic [UNIT_W-1:0] u;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			case ($urandom_range(0, 4))
				0:       u = CH_AMP;
				1:       u = CH_LT;
				2:       u = CH_GT;
				3:       u = CH_QUOT;
				default: u = CH_APOS;
			endcase
		end else if (pick < 40) begin
			u = UNIT_W'($urandom_range(0, 31));
		end else if (pick < 70) begin
			u = UNIT_W'($urandom_range(32, 126));
		end else begin
			u = UNIT_W'($urandom_range(0, 65535));
		end
		return u;
	endfunction

	initial begin
		logic [UNIT_W-1:0] directed[$];
		units_queued   = 0;
		units_accepted = 0;
		results_seen   = 0;
		mismatches     = 0;
		directed = '{16'h0000, 16'h001F, CH_TAB, CH_LF, CH_CR, 16'h0008, 16'h000B,
			16'h000C, 16'h000E, CTRL_LIMIT, CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS,
			16'h0021, CH_SEMI, 16'h007F, 16'h8000, 16'hD800, 16'hDFFF, 16'hFFFE,
			16'hFFFF, CH_AMP, CH_APOS};
		foreach (directed[i])
			queue_unit(directed[i], 1'b0);
		for (int i = 0; i < RANDOM_UNITS; i++)
			queue_unit(random_unit(), (i == 0) || (i == DRAIN_AT));

		do @(negedge clk);
		while (units_accepted != units_queued || escaped_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	always @(negedge clk) begin
		text_item_t item;
		logic       next_valid;
		next_valid = text_in.valid;
		if (!arst_n) begin
			next_valid = 1'b0;
			send_gap   = 0;
		end else if (!text_in.valid || in_taken) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (text_pending.size() > 0 &&
					!(text_pending[0].drain_first && escaped_due.size() > 0)) begin
				item = text_pending.pop_front();
				text_in.code_unit <= item.unit;
				next_valid = 1'b1;
				if ($urandom_range(0, 19) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 12);
			end
		end
		text_in.valid <= next_valid;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			recv_wait = 0;
			recv_hold = 0;
			text_out.ready <= 1'b0;
		end else begin
			if (out_taken) begin
				if ($urandom_range(0, 19) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 12);
			end
			if (!recv_held && results_seen >= HOLD_AFTER) begin
				recv_held = 1'b1;
				recv_hold = HOLD_CYCLES;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				text_out.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				text_out.ready <= 1'b0;
			end else begin
				text_out.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		escaped_unit_t want;
		in_taken  <= arst_n && text_in.valid && text_in.ready;
		out_taken <= arst_n && text_out.valid && text_out.ready;
		if (arst_n && text_out.valid && text_out.ready) begin
			results_seen <= results_seen + 1;
			if (escaped_due.size() == 0) begin
				report_mismatch($sformatf("unexpected unit %h run_end %b",
					text_out.out_unit, text_out.run_end));
			end else begin
				want = escaped_due.pop_front();
				if (text_out.out_unit !== want.unit)
					report_mismatch($sformatf("out_unit %h, expected %h",
						text_out.out_unit, want.unit));
				if (text_out.run_end !== want.run_end)
					report_mismatch($sformatf("run_end %b, expected %b on unit %h",
						text_out.run_end, want.run_end, want.unit));
			end
		end
		if (arst_n && text_in.valid && text_in.ready) begin
			predict_escape(text_in.code_unit);
			units_accepted <= units_accepted + 1;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (text_in.valid && text_in.ready) ||
					(text_out.valid && text_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("stream stalled for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ xml_text_escaper.f @@
+incdir+rtl
rtl/xte_pkg.sv
rtl/xte_if.sv
rtl/xte_front.sv
rtl/xte_queue.sv
rtl/xte_back.sv
rtl/xml_text_escaper.sv
tb/xml_text_escaper_tb.sv
